// ===== rtl/rle565_pixel_fade_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// rle565_pixel_fade_decoder_assert.svh
// Assertion macros used by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef RLE565_PIXEL_FADE_DECODER_ASSERT_SVH
`define RLE565_PIXEL_FADE_DECODER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define RLE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define RLE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the next cycle.
`define RLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rle565_pkg.sv =====
// ----------------------------------------------------------------------------
// rle565_pkg
// Shared types, constants and color functions of the RLE565 pixel decoder.
// ----------------------------------------------------------------------------
package rle565_pkg;

	localparam int MAX_RUN    = 64;
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam int COUNT_W  = 7;
	localparam int COLOR_W  = 16;
	localparam int RGB_W    = 24;
	localparam int ADDR_W   = 23;
	localparam int WIDTH_W  = 12;
	localparam int HEIGHT_W = 12;
	localparam int PITCH_W  = 13;
	localparam int BRIGHT_W = 8;
	localparam int COL_W    = 11;
	localparam int ROW_W    = 12;
	localparam int PROD_W   = ROW_W + PITCH_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = 2;
	localparam int OQ_DEPTH = 2;
	localparam int OQ_PTR_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_ROW_PITCH    = 2'd2,
		REG_BRIGHTNESS   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic               new_image;
		logic [COUNT_W-1:0] count;
		logic [RGB_W-1:0]   rgb;
	} run_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [RGB_W-1:0]  rgb;
		logic              last;
	} pix_t;

	typedef struct packed {
		logic [WIDTH_W-1:0]  wide;
		logic [HEIGHT_W-1:0] high;
		logic [PITCH_W-1:0]  pitch;
	} geom_t;

	function automatic logic [7:0] scale_chan(input logic [7:0] c8,
		input logic [BRIGHT_W-1:0] bright);
		logic [15:0] prod;
		prod = 16'(c8) * 16'(bright);
		return prod[15:8];
	endfunction

	function automatic logic [RGB_W-1:0] convert_color(input logic [COLOR_W-1:0] c,
		input logic [BRIGHT_W-1:0] bright);
		logic [7:0] r8;
		logic [7:0] g8;
		logic [7:0] b8;
		r8 = {c[15:11], c[15:13]};
		g8 = {c[10:5], c[10:9]};
		b8 = {c[4:0], c[4:2]};
		return {scale_chan(r8, bright), scale_chan(g8, bright), scale_chan(b8, bright)};
	endfunction

endpackage

// ===== rtl/rle565_front.sv =====
// ----------------------------------------------------------------------------
// rle565_front
// Accepts runs, saturates the count, converts the color and queues the run.
// ----------------------------------------------------------------------------
module rle565_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [rle565_pkg::COUNT_W-1:0]     run_count,
	input  logic [rle565_pkg::COLOR_W-1:0]     color565,
	input  logic                               new_image,
	input  logic [rle565_pkg::BRIGHT_W-1:0]    bright,
	output logic                               run_valid,
	output rle565_pkg::run_t                   run,
	input  logic                               run_take
);

	rle565_pkg::run_t                  fifo_q [rle565_pkg::RQ_DEPTH];
	logic [rle565_pkg::RQ_PTR_W-1:0]   wr_ptr_q;
	logic [rle565_pkg::RQ_PTR_W-1:0]   rd_ptr_q;
	logic [rle565_pkg::RQ_PTR_W:0]     cnt_q;
	logic                              push_ok;
	logic                              pop_ok;
	logic [rle565_pkg::COUNT_W-1:0]    count_sat;
	rle565_pkg::run_t                  entry;

	assign full      = (cnt_q == (rle565_pkg::RQ_PTR_W+1)'(rle565_pkg::RQ_DEPTH));
	assign run_valid = (cnt_q != '0);
	assign push_ok   = push && !full;
	assign pop_ok    = run_take && run_valid;
	assign run       = fifo_q[rd_ptr_q];

	// clamp long runs
	assign count_sat = (run_count > rle565_pkg::COUNT_W'(rle565_pkg::MAX_RUN)) ?
		rle565_pkg::COUNT_W'(rle565_pkg::MAX_RUN) : run_count;

	always_comb begin
		entry.new_image = new_image;
		entry.count     = count_sat;
		entry.rgb       = rle565_pkg::convert_color(color565, bright);
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rle565_back.sv =====
// ----------------------------------------------------------------------------
// rle565_back
// Expands queued runs into pixels in raster order and buffers the results.
// ----------------------------------------------------------------------------
module rle565_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               run_valid,
	input  rle565_pkg::run_t                   run,
	output logic                               run_take,
	input  rle565_pkg::geom_t                  geom,
	output logic                               empty,
	input  logic                               pop,
	output logic [rle565_pkg::ADDR_W-1:0]      pixel_address,
	output logic [rle565_pkg::RGB_W-1:0]       pixel_rgb,
	output logic                               last_of_run
);

	logic                              active_q;
	logic [rle565_pkg::COUNT_W-1:0]    left_q;
	logic [rle565_pkg::RGB_W-1:0]      rgb_q;
	logic [rle565_pkg::COL_W-1:0]      col_q;
	logic [rle565_pkg::ROW_W-1:0]      row_q;

	rle565_pkg::pix_t                  oq_q [rle565_pkg::OQ_DEPTH];
	logic [rle565_pkg::OQ_PTR_W-1:0]   oq_wr_q;
	logic [rle565_pkg::OQ_PTR_W-1:0]   oq_rd_q;
	logic [rle565_pkg::OQ_PTR_W:0]     oq_cnt_q;

	logic                              room;
	logic                              in_image;
	logic                              emit;
	logic                              wrap;
	logic                              last;
	logic                              done;
	logic                              out_pop;
	logic [rle565_pkg::WIDTH_W-1:0]    col_inc;
	logic [rle565_pkg::ROW_W-1:0]      row_inc;
	logic [rle565_pkg::COL_W-1:0]      col_nx;
	logic [rle565_pkg::ROW_W-1:0]      row_nx;
	logic [rle565_pkg::PROD_W-1:0]     prod;
	logic [rle565_pkg::PROD_W-1:0]     addr_sum;
	rle565_pkg::pix_t                  pix;
	rle565_pkg::pix_t                  head;

	assign room     = (oq_cnt_q != (rle565_pkg::OQ_PTR_W+1)'(rle565_pkg::OQ_DEPTH));
	assign in_image = (row_q < geom.high);
	assign emit     = active_q && in_image && room;

	assign col_inc  = rle565_pkg::WIDTH_W'(col_q) + 1'b1;
	assign row_inc  = row_q + 1'b1;
	assign wrap     = (col_inc >= geom.wide);
	assign col_nx   = wrap ? '0 : col_inc[rle565_pkg::COL_W-1:0];
	assign row_nx   = wrap ? row_inc : row_q;

	// last pixel of the run, or last pixel that still fits in the image
	assign last     = (left_q == rle565_pkg::COUNT_W'(1)) || (wrap && !(row_inc < geom.high));
	assign done     = active_q && (!in_image || (emit && last));
	assign run_take = run_valid && (!active_q || done);

	assign prod     = rle565_pkg::PROD_W'(row_q) * rle565_pkg::PROD_W'(geom.pitch);
	assign addr_sum = prod + rle565_pkg::PROD_W'(col_q);

	always_comb begin
		pix.addr = addr_sum[rle565_pkg::ADDR_W-1:0];
		pix.rgb  = rgb_q;
		pix.last = last;
	end

	always_ff @(posedge clk) begin
		if (run_take) begin
			rgb_q <= run.rgb;
		end
		if (emit) begin
			oq_q[oq_wr_q] <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			left_q   <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (run_take) begin
				if (run.new_image) begin
					col_q <= '0;
					row_q <= '0;
				end else if (emit) begin
					col_q <= col_nx;
					row_q <= row_nx;
				end
				left_q   <= run.count;
				active_q <= (run.count != '0);
			end else begin
				if (emit) begin
					col_q  <= col_nx;
					row_q  <= row_nx;
					left_q <= left_q - 1'b1;
				end
				if (done) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	assign empty   = (oq_cnt_q == '0);
	assign out_pop = pop && !empty;
	assign head    = oq_q[oq_rd_q];

	assign pixel_address = head.addr;
	assign pixel_rgb     = head.rgb;
	assign last_of_run   = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (emit) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (out_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			if (emit && !out_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (out_pop && !emit) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rle565_pixel_fade_decoder.sv =====
// Path: pushed runs go through the run queue and pixel sequencer into the result queue.
// Throughput: the pixel sequencer writes one pixel per cycle while the result queue has
//   room, and takes the next run together with the last pixel of the current run.
// The run queue holds 4 runs and the result queue 2 pixels.
// Reset: arst_n clears queues, position and run state; registers return to
//   640 x 480, pitch 640, brightness 255.
// ----------------------------------------------------------------------------
// rle565_pixel_fade_decoder
// Run-length RGB565 decoder that writes faded RGB888 pixels in raster order.
// ----------------------------------------------------------------------------
module rle565_pixel_fade_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [rle565_pkg::COUNT_W-1:0]       run_count,
	input  logic [rle565_pkg::COLOR_W-1:0]       color565,
	input  logic                                 new_image,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [rle565_pkg::ADDR_W-1:0]        pixel_address,
	output logic [rle565_pkg::RGB_W-1:0]         pixel_rgb,
	output logic                                 last_of_run,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rle565_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rle565_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [rle565_pkg::WIDTH_W-1:0]   width_q;
	logic [rle565_pkg::HEIGHT_W-1:0]  height_q;
	logic [rle565_pkg::PITCH_W-1:0]   pitch_q;
	logic [rle565_pkg::BRIGHT_W-1:0]  bright_q;
	rle565_pkg::geom_t                geom;
	rle565_pkg::run_t                 run;
	logic                             run_valid;
	logic                             run_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rle565_pkg::WIDTH_W'(640);
			height_q <= rle565_pkg::HEIGHT_W'(480);
			pitch_q  <= rle565_pkg::PITCH_W'(640);
			bright_q <= rle565_pkg::BRIGHT_W'(255);
		end else if (cfg_valid && cfg_ready) begin
			case (rle565_pkg::cfg_reg_t'(cfg_index))
				rle565_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[rle565_pkg::WIDTH_W-1:0];
				end
				rle565_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[rle565_pkg::HEIGHT_W-1:0];
				end
				rle565_pkg::REG_ROW_PITCH: begin
					pitch_q <= cfg_data;
				end
				rle565_pkg::REG_BRIGHTNESS: begin
					bright_q <= cfg_data[rle565_pkg::BRIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// clamp oversized width and height
	always_comb begin
		geom.wide  = (width_q > rle565_pkg::WIDTH_W'(rle565_pkg::MAX_WIDTH)) ?
			rle565_pkg::WIDTH_W'(rle565_pkg::MAX_WIDTH) : width_q;
		geom.high  = (height_q > rle565_pkg::HEIGHT_W'(rle565_pkg::MAX_HEIGHT)) ?
			rle565_pkg::HEIGHT_W'(rle565_pkg::MAX_HEIGHT) : height_q;
		geom.pitch = pitch_q;
	end

	rle565_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.run_count (run_count),
		.color565  (color565),
		.new_image (new_image),
		.bright    (bright_q),
		.run_valid (run_valid),
		.run       (run),
		.run_take  (run_take)
	);

	rle565_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.run_valid     (run_valid),
		.run           (run),
		.run_take      (run_take),
		.geom          (geom),
		.empty         (empty),
		.pop           (pop),
		.pixel_address (pixel_address),
		.pixel_rgb     (pixel_rgb),
		.last_of_run   (last_of_run)
	);

endmodule

// ===== rtl/rle565_chk.sv =====
// ----------------------------------------------------------------------------
// rle565_chk
// Port-level checks of the RLE565 pixel decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "rle565_pixel_fade_decoder_assert.svh"

module rle565_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 push,
	input logic                                 full,
	input logic                                 empty,
	input logic                                 pop,
	input logic [rle565_pkg::ADDR_W-1:0]        pixel_address,
	input logic [rle565_pkg::RGB_W-1:0]         pixel_rgb,
	input logic                                 last_of_run,
	input logic                                 cfg_ready
);

	`RLE_ASSERT_NEXT(a_word_held, !empty && !pop, !empty && $stable(pixel_address) && $stable(pixel_rgb) && $stable(last_of_run), "result word changed while waiting")
	`RLE_ASSERT_IMPL(a_chan_range, !empty, pixel_rgb[23:16] != 8'hFF && pixel_rgb[15:8] != 8'hFF && pixel_rgb[7:0] != 8'hFF, "scaled channel out of range")
	`RLE_ASSERT_IMPL(a_full_rise, $rose(full), $past(push), "run queue filled without a push")
	`RLE_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port not ready")

endmodule

bind rle565_pixel_fade_decoder rle565_chk u_chk (.*);
